[src/bpq_pkg.sv]
// ----------------------------------------------------------------------------
// bpq_pkg
// Shared types, codes and helpers of the buffer pool with three-queue
// replacement: state machine codes, controller/datapath bundles, status codes.
// ----------------------------------------------------------------------------
package bpq_pkg;

    // default sizes
    localparam int DEF_NUM_PAGES   = 1024;
    localparam int DEF_NUM_FRAMES  = 64;
    localparam int DEF_MAX_HOLDERS = 15;

    // fixed field widths
    localparam int PAGE_W     = 10;
    localparam int SLOT_OUT_W = 6;
    localparam int STATUS_W   = 3;
    localparam int LIMIT_W    = 7;
    localparam int CNT_W      = 16;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 24;

    localparam logic [LIMIT_W-1:0] FRAME_LIMIT_RESET = 7'd64;
    localparam logic [CNT_W-1:0]   CNT_MAX           = 16'hFFFF;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_GRANTED      = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_BLOCKED      = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_NO_FRAME     = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_BAD_PAGE     = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NOT_RESIDENT = 3'd4;

    // queue codes of a frame
    localparam logic [1:0] Q_NONE  = 2'd0;
    localparam logic [1:0] Q_FIRST = 2'd1;
    localparam logic [1:0] Q_REUSE = 2'd2;
    localparam logic [1:0] Q_HOT   = 2'd3;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_LOOK, ST_UNFIX, ST_FIXHIT, ST_EVICT, ST_ALLOC, ST_DONE
    } state_t;

    // datapath operations
    typedef enum logic [2:0] {
        OP_CLEAR, OP_IDLE, OP_LOOK, OP_UNFIX, OP_FIXHIT, OP_EVICT, OP_ALLOC, OP_FLUSH
    } op_t;

    // outcome of the page lookup
    typedef enum logic [2:0] {
        LK_DONE, LK_UNFIX, LK_FIXHIT, LK_ALLOC, LK_EVICT
    } look_t;

    typedef struct packed {
        op_t  op;
        logic ready;
    } cmd_t;

    typedef struct packed {
        logic  clear_last;
        look_t look;
        logic  evict_alloc;
        logic  out_free;
    } sts_t;

    // saturating counter increment
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 16'd1;
    endfunction

endpackage

[src/bpq_ctrl.sv]
// ----------------------------------------------------------------------------
// bpq_ctrl
// Sequencer of the buffer pool: clearing pass, lookup, update steps per request
// kind, and hand-off of the result to the output register.
// ----------------------------------------------------------------------------
module bpq_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    input  bpq_pkg::sts_t sts,
    output bpq_pkg::cmd_t cmd
);

    bpq_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bpq_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bpq_pkg::ST_CLEAR: begin
                if (sts.clear_last) state_next = bpq_pkg::ST_IDLE;
            end
            bpq_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = bpq_pkg::ST_LOOK;
            end
            bpq_pkg::ST_LOOK: begin
                case (sts.look)
                    bpq_pkg::LK_UNFIX:  state_next = bpq_pkg::ST_UNFIX;
                    bpq_pkg::LK_FIXHIT: state_next = bpq_pkg::ST_FIXHIT;
                    bpq_pkg::LK_ALLOC:  state_next = bpq_pkg::ST_ALLOC;
                    bpq_pkg::LK_EVICT:  state_next = bpq_pkg::ST_EVICT;
                    default:            state_next = bpq_pkg::ST_DONE;
                endcase
            end
            bpq_pkg::ST_UNFIX:  state_next = bpq_pkg::ST_DONE;
            bpq_pkg::ST_FIXHIT: state_next = bpq_pkg::ST_DONE;
            bpq_pkg::ST_EVICT: begin
                state_next = sts.evict_alloc ? bpq_pkg::ST_ALLOC : bpq_pkg::ST_DONE;
            end
            bpq_pkg::ST_ALLOC:  state_next = bpq_pkg::ST_DONE;
            bpq_pkg::ST_DONE: begin
                if (sts.out_free) state_next = bpq_pkg::ST_IDLE;
            end
            default: state_next = bpq_pkg::ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        cmd.ready = 1'b0;
        case (state_reg)
            bpq_pkg::ST_CLEAR:  cmd.op = bpq_pkg::OP_CLEAR;
            bpq_pkg::ST_IDLE: begin
                cmd.op    = bpq_pkg::OP_IDLE;
                cmd.ready = 1'b1;
            end
            bpq_pkg::ST_LOOK:   cmd.op = bpq_pkg::OP_LOOK;
            bpq_pkg::ST_UNFIX:  cmd.op = bpq_pkg::OP_UNFIX;
            bpq_pkg::ST_FIXHIT: cmd.op = bpq_pkg::OP_FIXHIT;
            bpq_pkg::ST_EVICT:  cmd.op = bpq_pkg::OP_EVICT;
            bpq_pkg::ST_ALLOC:  cmd.op = bpq_pkg::OP_ALLOC;
            bpq_pkg::ST_DONE:   cmd.op = bpq_pkg::OP_FLUSH;
            default:            cmd.op = bpq_pkg::OP_IDLE;
        endcase
    end

endmodule

[src/bpq_dp.sv]
// ----------------------------------------------------------------------------
// bpq_dp
// Datapath of the buffer pool: page table, frame table, queue links as
// linked lists, occupancy bits, result and output registers.
// ----------------------------------------------------------------------------
module bpq_dp #(
    parameter int NUM_PAGES   = bpq_pkg::DEF_NUM_PAGES,
    parameter int NUM_FRAMES  = bpq_pkg::DEF_NUM_FRAMES,
    parameter int MAX_HOLDERS = bpq_pkg::DEF_MAX_HOLDERS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  bpq_pkg::cmd_t                    cmd,
    output bpq_pkg::sts_t                    sts,
    input  logic                             s_tvalid,
    input  logic [bpq_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                             s_tuser,
    input  logic                             cfg_we,
    input  logic [bpq_pkg::LIMIT_W-1:0]      cfg_wdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [bpq_pkg::M_TDATA_W-1:0]    m_tdata
);

    localparam int PAW  = $clog2(NUM_PAGES);
    localparam int SW   = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int HW   = $clog2(MAX_HOLDERS + 1);
    localparam int LW   = $clog2(NUM_FRAMES + 1);
    localparam int CW   = (LW > bpq_pkg::LIMIT_W) ? LW : bpq_pkg::LIMIT_W;
    localparam int PGW  = bpq_pkg::PAGE_W;
    localparam int CNTW = bpq_pkg::CNT_W;

    typedef struct packed {
        logic [PGW-1:0]  page;
        logic [HW-1:0]   holders;
        logic            excl;
        logic            dirty;
        logic [CNTW-1:0] hits;
        logic [1:0]      queue;
    } slot_word_t;

    typedef struct packed {
        logic [CNTW-1:0] fix;
        logic [SW-1:0]   slot;
    } info_word_t;

    // memories
    logic       res_mem  [NUM_PAGES];
    info_word_t info_mem [NUM_PAGES];
    slot_word_t slot_mem [NUM_FRAMES];
    logic [SW-1:0] prev_mem [NUM_FRAMES];
    logic [SW-1:0] next_mem [NUM_FRAMES];

    logic          res_rd_reg;
    info_word_t    info_rd_reg;
    slot_word_t    slot_rd_reg;
    logic          sv_rd_reg;
    logic [SW-1:0] prev_rd_reg;
    logic [SW-1:0] next_rd_reg;

    // control registers
    logic [PAW-1:0]              clr_cnt_reg, clr_cnt_next;
    logic [NUM_FRAMES-1:0]       occ_reg, occ_next;
    logic [NUM_FRAMES-1:0]       sv_reg, sv_next;
    logic [2:0]                  ne_reg, ne_next;
    logic [bpq_pkg::LIMIT_W-1:0] frame_limit_reg, frame_limit_next;
    logic                        m_valid_reg, m_valid_next;

    // payload registers
    logic [SW-1:0]   head_reg [3];
    logic [SW-1:0]   head_next [3];
    logic [SW-1:0]   tail_reg [3];
    logic [SW-1:0]   tail_next [3];
    logic            req_unfix_reg, req_unfix_next;
    logic [PGW-1:0]  req_page_reg, req_page_next;
    logic            req_excl_reg, req_excl_next;
    logic            req_dirty_reg, req_dirty_next;
    logic [CNTW-1:0] fix_reg, fix_next;
    logic [SW-1:0]   slot_reg, slot_next;
    logic [bpq_pkg::STATUS_W-1:0] rs_status_reg, rs_status_next;
    logic [SW-1:0]   rs_slot_reg, rs_slot_next;
    logic            rs_load_reg, rs_load_next;
    logic            rs_ev_reg, rs_ev_next;
    logic [PGW-1:0]  rs_evp_reg, rs_evp_next;
    logic            rs_wb_reg, rs_wb_next;
    logic [bpq_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;

    // memory ports
    logic [PAW-1:0] pg_raddr;
    logic           res_we, res_wdata;
    logic [PAW-1:0] res_waddr;
    logic           info_we;
    logic [PAW-1:0] info_waddr;
    info_word_t     info_wdata;
    logic [SW-1:0]  sl_raddr;
    logic           sl_we;
    slot_word_t     sl_wdata;
    logic           nx_we, pv_we;
    logic [SW-1:0]  nx_waddr, nx_wdata, pv_waddr, pv_wdata;

    // lookup helpers
    logic          acc;
    logic [CW-1:0] lim_w;
    logic          any_free, any_ne, in_lim, pg_invalid;
    logic [SW-1:0] free_idx, victim_head, look_slot;
    logic [1:0]    vq, uq, pq, push_q;
    slot_word_t    sd, w;
    logic          do_unlink, do_push, out_free, blocked;

    assign acc      = cmd.ready & s_tvalid;
    assign out_free = !m_valid_reg || m_tready;
    assign lim_w    = (CW'(frame_limit_reg) > CW'(NUM_FRAMES)) ? CW'(NUM_FRAMES)
                                                               : CW'(frame_limit_reg);
    assign pg_invalid = 32'(req_page_reg) >= 32'(NUM_PAGES);
    assign in_lim     = CW'(slot_reg) < lim_w;

    // lowest unoccupied frame below the limit
    always_comb begin
        any_free = 1'b0;
        free_idx = '0;
        for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
            if (!occ_reg[i] && (CW'(i) < lim_w)) begin
                any_free = 1'b1;
                free_idx = SW'(i);
            end
        end
    end

    // victim queue: first-use, then reuse, then hot
    assign any_ne      = |ne_reg;
    assign vq          = ne_reg[0] ? 2'd0 : (ne_reg[1] ? 2'd1 : 2'd2);
    assign victim_head = head_reg[vq];
    assign look_slot   = res_rd_reg ? info_rd_reg.slot : (any_free ? free_idx : victim_head);

    // frame read data, never-written entries read as reset
    always_comb begin
        sd = slot_rd_reg;
        if (!sv_rd_reg) begin
            sd.holders = '0;
            sd.excl    = 1'b0;
            sd.dirty   = 1'b0;
            sd.hits    = '0;
            sd.queue   = bpq_pkg::Q_NONE;
        end
    end

    assign uq      = 2'(sd.queue - 2'd1);
    assign blocked = ((req_excl_reg || sd.excl) && (sd.holders != '0)) ||
                     (sd.holders >= HW'(MAX_HOLDERS));

    // status to controller
    always_comb begin
        sts.clear_last  = (clr_cnt_reg == PAW'(NUM_PAGES - 1));
        sts.evict_alloc = in_lim;
        sts.out_free    = out_free;
        if (pg_invalid) begin
            sts.look = bpq_pkg::LK_DONE;
        end else if (req_unfix_reg) begin
            sts.look = res_rd_reg ? bpq_pkg::LK_UNFIX : bpq_pkg::LK_DONE;
        end else if (res_rd_reg) begin
            sts.look = bpq_pkg::LK_FIXHIT;
        end else if (any_free) begin
            sts.look = bpq_pkg::LK_ALLOC;
        end else if (any_ne) begin
            sts.look = bpq_pkg::LK_EVICT;
        end else begin
            sts.look = bpq_pkg::LK_DONE;
        end
    end

    assign pg_raddr = cmd.ready ? PAW'(s_tdata[PGW-1:0]) : PAW'(req_page_reg);
    assign sl_raddr = (cmd.op == bpq_pkg::OP_LOOK) ? look_slot : slot_reg;

    // next values
    always_comb begin
        clr_cnt_next     = clr_cnt_reg;
        occ_next         = occ_reg;
        sv_next          = sv_reg;
        ne_next          = ne_reg;
        frame_limit_next = frame_limit_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        req_unfix_next   = req_unfix_reg;
        req_page_next    = req_page_reg;
        req_excl_next    = req_excl_reg;
        req_dirty_next   = req_dirty_reg;
        fix_next         = fix_reg;
        slot_next        = slot_reg;
        rs_status_next   = rs_status_reg;
        rs_slot_next     = rs_slot_reg;
        rs_load_next     = rs_load_reg;
        rs_ev_next       = rs_ev_reg;
        rs_evp_next      = rs_evp_reg;
        rs_wb_next       = rs_wb_reg;
        res_we     = 1'b0;
        res_waddr  = PAW'(req_page_reg);
        res_wdata  = 1'b0;
        info_we    = 1'b0;
        info_waddr = PAW'(req_page_reg);
        info_wdata = '{fix: bpq_pkg::sat_inc(fix_reg), slot: slot_reg};
        sl_we      = 1'b0;
        w          = sd;
        nx_we      = 1'b0;
        nx_waddr   = slot_reg;
        nx_wdata   = slot_reg;
        pv_we      = 1'b0;
        pv_waddr   = slot_reg;
        pv_wdata   = slot_reg;
        do_unlink  = 1'b0;
        do_push    = 1'b0;
        push_q     = bpq_pkg::Q_NONE;

        if (cfg_we) frame_limit_next = cfg_wdata;

        // request capture
        if (acc) begin
            req_unfix_next = s_tuser;
            req_page_next  = s_tdata[PGW-1:0];
            req_excl_next  = s_tdata[PGW];
            req_dirty_next = s_tdata[PGW+1];
        end

        if (m_tready) m_valid_next = 1'b0;

        case (cmd.op)
            bpq_pkg::OP_CLEAR: begin
                res_we       = 1'b1;
                res_waddr    = clr_cnt_reg;
                info_we      = 1'b1;
                info_waddr   = clr_cnt_reg;
                info_wdata   = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            bpq_pkg::OP_LOOK: begin
                fix_next       = info_rd_reg.fix;
                slot_next      = look_slot;
                rs_status_next = bpq_pkg::STAT_GRANTED;
                rs_slot_next   = '0;
                rs_load_next   = 1'b0;
                rs_ev_next     = 1'b0;
                rs_evp_next    = '0;
                rs_wb_next     = 1'b0;
                if (pg_invalid) begin
                    rs_status_next = bpq_pkg::STAT_BAD_PAGE;
                end else if (req_unfix_reg) begin
                    if (!res_rd_reg) rs_status_next = bpq_pkg::STAT_NOT_RESIDENT;
                end else if (!res_rd_reg && !any_free && !any_ne) begin
                    rs_status_next = bpq_pkg::STAT_NO_FRAME;
                end
            end
            bpq_pkg::OP_UNFIX: begin
                if (req_dirty_reg) w.dirty = 1'b1;
                if (sd.holders != '0) begin
                    w.holders = sd.holders - 1'b1;
                    if (w.holders == '0) begin
                        if (sd.hits > 16'd1) begin
                            push_q = bpq_pkg::Q_HOT;
                        end else if (fix_reg == 16'd1) begin
                            push_q = bpq_pkg::Q_FIRST;
                        end else begin
                            push_q = bpq_pkg::Q_REUSE;
                        end
                        w.queue = push_q;
                        do_push = 1'b1;
                    end
                end
                sl_we              = 1'b1;
                occ_next[slot_reg] = (w.holders != '0) || (w.queue != bpq_pkg::Q_NONE);
                rs_slot_next       = slot_reg;
            end
            bpq_pkg::OP_FIXHIT: begin
                if (blocked) begin
                    rs_status_next = bpq_pkg::STAT_BLOCKED;
                end else begin
                    do_unlink          = (sd.queue != bpq_pkg::Q_NONE);
                    w.holders          = sd.holders + HW'(1);
                    w.hits             = bpq_pkg::sat_inc(sd.hits);
                    w.excl             = req_excl_reg;
                    w.queue            = bpq_pkg::Q_NONE;
                    sl_we              = 1'b1;
                    occ_next[slot_reg] = 1'b1;
                    info_we            = 1'b1;
                    rs_slot_next       = slot_reg;
                end
            end
            bpq_pkg::OP_EVICT: begin
                do_unlink          = (sd.queue != bpq_pkg::Q_NONE);
                res_we             = 1'b1;
                res_waddr          = PAW'(sd.page);
                res_wdata          = 1'b0;
                w.excl             = 1'b0;
                w.dirty            = 1'b0;
                w.hits             = '0;
                w.queue            = bpq_pkg::Q_NONE;
                sl_we              = 1'b1;
                occ_next[slot_reg] = 1'b0;
                rs_ev_next         = 1'b1;
                rs_evp_next        = sd.page;
                rs_wb_next         = sd.dirty;
                if (!in_lim) rs_status_next = bpq_pkg::STAT_NO_FRAME;
            end
            bpq_pkg::OP_ALLOC: begin
                w = '{page: req_page_reg, holders: HW'(1), excl: req_excl_reg,
                      dirty: 1'b0, hits: '0, queue: bpq_pkg::Q_NONE};
                sl_we              = 1'b1;
                occ_next[slot_reg] = 1'b1;
                res_we             = 1'b1;
                res_wdata          = 1'b1;
                info_we            = 1'b1;
                rs_status_next     = bpq_pkg::STAT_GRANTED;
                rs_slot_next       = slot_reg;
                rs_load_next       = 1'b1;
            end
            bpq_pkg::OP_FLUSH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {2'b00, rs_wb_reg, rs_evp_reg, rs_ev_reg, rs_load_reg,
                                    bpq_pkg::SLOT_OUT_W'(rs_slot_reg), rs_status_reg};
                end
            end
            default: begin
            end
        endcase

        if (sl_we) sv_next[slot_reg] = 1'b1;

        // remove the frame from its queue
        if (do_unlink) begin
            if (head_reg[uq] == slot_reg && tail_reg[uq] == slot_reg) begin
                ne_next[uq] = 1'b0;
            end else if (head_reg[uq] == slot_reg) begin
                head_next[uq] = next_rd_reg;
            end else if (tail_reg[uq] == slot_reg) begin
                tail_next[uq] = prev_rd_reg;
            end else begin
                nx_we    = 1'b1;
                nx_waddr = prev_rd_reg;
                nx_wdata = next_rd_reg;
                pv_we    = 1'b1;
                pv_waddr = next_rd_reg;
                pv_wdata = prev_rd_reg;
            end
        end

        // append the frame at the tail of its new queue
        pq = 2'(push_q - 2'd1);
        if (do_push) begin
            if (ne_reg[pq]) begin
                nx_we         = 1'b1;
                nx_waddr      = tail_reg[pq];
                nx_wdata      = slot_reg;
                pv_we         = 1'b1;
                pv_waddr      = slot_reg;
                pv_wdata      = tail_reg[pq];
                tail_next[pq] = slot_reg;
            end else begin
                head_next[pq] = slot_reg;
                tail_next[pq] = slot_reg;
                ne_next[pq]   = 1'b1;
            end
        end
        sl_wdata = w;
    end

    // page table
    always_ff @(posedge aclk) begin
        if (res_we) res_mem[res_waddr] <= res_wdata;
        if (info_we) info_mem[info_waddr] <= info_wdata;
        res_rd_reg  <= res_mem[pg_raddr];
        info_rd_reg <= info_mem[pg_raddr];
    end

    // frame table and queue links
    always_ff @(posedge aclk) begin
        if (sl_we) slot_mem[slot_reg] <= sl_wdata;
        if (nx_we) next_mem[nx_waddr] <= nx_wdata;
        if (pv_we) prev_mem[pv_waddr] <= pv_wdata;
        slot_rd_reg <= slot_mem[sl_raddr];
        sv_rd_reg   <= sv_reg[sl_raddr];
        next_rd_reg <= next_mem[sl_raddr];
        prev_rd_reg <= prev_mem[sl_raddr];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg     <= '0;
            occ_reg         <= '0;
            sv_reg          <= '0;
            ne_reg          <= '0;
            frame_limit_reg <= bpq_pkg::FRAME_LIMIT_RESET;
            m_valid_reg     <= 1'b0;
        end else begin
            clr_cnt_reg     <= clr_cnt_next;
            occ_reg         <= occ_next;
            sv_reg          <= sv_next;
            ne_reg          <= ne_next;
            frame_limit_reg <= frame_limit_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        head_reg      <= head_next;
        tail_reg      <= tail_next;
        req_unfix_reg <= req_unfix_next;
        req_page_reg  <= req_page_next;
        req_excl_reg  <= req_excl_next;
        req_dirty_reg <= req_dirty_next;
        fix_reg       <= fix_next;
        slot_reg      <= slot_next;
        rs_status_reg <= rs_status_next;
        rs_slot_reg   <= rs_slot_next;
        rs_load_reg   <= rs_load_next;
        rs_ev_reg     <= rs_ev_next;
        rs_evp_reg    <= rs_evp_next;
        rs_wb_reg     <= rs_wb_next;
        m_data_reg    <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

[src/buffer_pool_2q_replacement_core.sv]
// ----------------------------------------------------------------------------
// buffer_pool_2q_replacement_core
// Page buffer pool with first-use / reuse / hot replacement queues.
//
//   channel  direction  fields (lsb first)
//   s_       in         tdata: page_id[9:0] exclusive[10] dirty[11]; tuser: action
//   m_       out        tdata: status[2:0] frame_slot[8:3] load_needed[9]
//                              evict_valid[10] evicted_page[20:11] writeback[21]
//   cfg_     in         wdata: frame_limit[6:0]
//
// A request steps from the page lookup through its update step to the result
// hand-off; a frame that is evicted and refilled takes an eviction step and then
// an allocation step, and requests settled at the page lookup go straight to
// the hand-off.
// After reset a clearing pass runs over the whole page table while s_tready stays low.
// A finished result waits in the output register; the next request is taken
// meanwhile and holds in its last step until the output register frees.
// ----------------------------------------------------------------------------
module buffer_pool_2q_replacement_core #(
    parameter int NUM_PAGES   = bpq_pkg::DEF_NUM_PAGES,
    parameter int NUM_FRAMES  = bpq_pkg::DEF_NUM_FRAMES,
    parameter int MAX_HOLDERS = bpq_pkg::DEF_MAX_HOLDERS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bpq_pkg::S_TDATA_W-1:0] s_tdata,   // page_id, exclusive, dirty
    input  logic                          s_tuser,   // action
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bpq_pkg::M_TDATA_W-1:0] m_tdata,   // status, frame_slot, load_needed,
                                                     // evict_valid, evicted_page, writeback
    input  logic                          cfg_we,
    input  logic [bpq_pkg::LIMIT_W-1:0]   cfg_wdata
);

    bpq_pkg::cmd_t cmd;
    bpq_pkg::sts_t sts;

    bpq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .sts      (sts),
        .cmd      (cmd)
    );

    bpq_dp #(
        .NUM_PAGES   (NUM_PAGES),
        .NUM_FRAMES  (NUM_FRAMES),
        .MAX_HOLDERS (MAX_HOLDERS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    assign s_tready = cmd.ready;

    // one transaction in flight at a time
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second transaction accepted while busy");

    // status code stays in range
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] <= bpq_pkg::STAT_NOT_RESIDENT))
        else $error("status code out of range");

    // no frame and no load unless granted
    a_refused_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[2:0] != bpq_pkg::STAT_GRANTED))
            |-> (m_tdata[8:3] == 6'd0 && !m_tdata[9]))
        else $error("frame or load reported on refused request");

    // eviction fields are zero without an eviction
    a_evict_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[10]) |-> (m_tdata[21:11] == 11'd0))
        else $error("eviction fields set without eviction");

endmodule

[tb/buffer_pool_2q_replacement_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// buffer_pool_2q_replacement_core_tb
// Streams fix and unfix requests into the buffer pool, predicts every result
// with a local model of the three replacement queues and compares field by
// field; both sides idle at random but in the last phase, and the frame limit changes between phases.
// ----------------------------------------------------------------------------
module buffer_pool_2q_replacement_core_tb;

    localparam int NPG = 1024;
    localparam int NFR = 64;
    localparam int MAXH = 15;

    typedef struct packed {
        logic       action;
        logic [9:0] page;
        logic       excl;
        logic       dirty;
    } req_t;

    // lowest field in the lowest bits, as on m_tdata
    typedef struct packed {
        logic       wb;
        logic [9:0] evp;
        logic       ev;
        logic       load;
        logic [5:0] slot;
        logic [2:0] status;
    } rsp_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [bpq_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic s_tuser = 0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [bpq_pkg::M_TDATA_W-1:0] m_tdata;
    logic cfg_we = 0;
    logic [bpq_pkg::LIMIT_W-1:0] cfg_wdata = '0;

    // pool model state
    logic        pg_res [NPG];
    logic [5:0]  pg_slot [NPG];
    logic [15:0] pg_fixes [NPG];
    logic [9:0]  fr_page [NFR];
    logic [3:0]  fr_hold [NFR];
    logic        fr_excl [NFR];
    logic        fr_dirty [NFR];
    logic [15:0] fr_hits [NFR];
    logic [1:0]  fr_q [NFR];
    logic [5:0]  lru_q [1:3][$];
    int          free_frames;
    int          lim;

    req_t pending_reqs[$];
    rsp_t expected_rsps[$];
    int   errors = 0;
    int   n_sent = 0;
    int   n_recv = 0;
    bit   calm = 0;
    bit   s_taken = 0;

    buffer_pool_2q_replacement_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always #1 aclk = ~aclk;

    function automatic logic [15:0] sat16(logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic int usable_frames();
        return (lim > NFR) ? NFR : lim;
    endfunction

    function automatic bit frame_busy(int s);
        return fr_hold[s] != 0 || fr_q[s] != bpq_pkg::Q_NONE;
    endfunction

    function automatic void recount_free();
        free_frames = 0;
        for (int s = 0; s < usable_frames(); s++)
            if (!frame_busy(s)) free_frames++;
    endfunction

    function automatic void unlink_frame(int s);
        int q;
        q = fr_q[s];
        if (q != 0)
            for (int i = 0; i < lru_q[q].size(); i++)
                if (lru_q[q][i] == s) begin
                    lru_q[q].delete(i);
                    break;
                end
        fr_q[s] = bpq_pkg::Q_NONE;
    endfunction

    function automatic void set_limit(int v);
        lim = v;
        recount_free();
    endfunction

    function automatic void pool_reset();
        for (int p = 0; p < NPG; p++) begin
            pg_res[p] = 0; pg_slot[p] = 0; pg_fixes[p] = 0;
        end
        for (int s = 0; s < NFR; s++) begin
            fr_page[s] = 0; fr_hold[s] = 0; fr_excl[s] = 0;
            fr_dirty[s] = 0; fr_hits[s] = 0; fr_q[s] = bpq_pkg::Q_NONE;
        end
        for (int q = 1; q <= 3; q++) lru_q[q].delete();
        set_limit(64);
    endfunction

    // predict the result of one request and update the pool model
    function automatic rsp_t predict_pool(req_t r);
        rsp_t o;
        int s, got, q, v;
        o = '0;
        if (r.action) begin
            if (!pg_res[r.page]) o.status = bpq_pkg::STAT_NOT_RESIDENT;
            else begin
                s = pg_slot[r.page];
                o.slot = 6'(s);
                if (r.dirty) fr_dirty[s] = 1;
                if (fr_hold[s] != 0) begin
                    fr_hold[s]--;
                    if (fr_hold[s] == 0) begin
                        q = (fr_hits[s] > 1) ? 3 : (pg_fixes[r.page] == 1) ? 1 : 2;
                        lru_q[q] = {lru_q[q], 6'(s)};
                        fr_q[s] = 2'(q);
                    end
                end
            end
        end else if (pg_res[r.page]) begin
            s = pg_slot[r.page];
            if (((r.excl || fr_excl[s]) && fr_hold[s] != 0) || fr_hold[s] >= MAXH)
                o.status = bpq_pkg::STAT_BLOCKED;
            else begin
                unlink_frame(s);
                fr_hold[s]++;
                pg_fixes[r.page] = sat16(pg_fixes[r.page]);
                fr_hits[s] = sat16(fr_hits[s]);
                fr_excl[s] = r.excl;
                o.slot = 6'(s);
            end
        end else begin
            got = NFR;
            if (free_frames > 0) begin
                for (s = 0; s < usable_frames(); s++)
                    if (!frame_busy(s)) begin
                        got = s;
                        break;
                    end
                if (got < NFR) free_frames--;
            end else begin
                q = lru_q[1].size() ? 1 : lru_q[2].size() ? 2 : lru_q[3].size() ? 3 : 0;
                if (q != 0) begin
                    v = lru_q[q][0];
                    unlink_frame(v);
                    o.ev = 1;
                    o.evp = fr_page[v];
                    o.wb = fr_dirty[v];
                    pg_res[fr_page[v]] = 0;
                    fr_dirty[v] = 0; fr_hits[v] = 0; fr_excl[v] = 0;
                    if (v < usable_frames()) got = v;
                end
            end
            if (got < NFR) begin
                pg_fixes[r.page] = sat16(pg_fixes[r.page]);
                pg_res[r.page] = 1;
                pg_slot[r.page] = 6'(got);
                fr_page[got] = r.page;
                fr_hold[got] = 1;
                fr_excl[got] = r.excl;
                fr_dirty[got] = 0;
                fr_hits[got] = 0;
                o.slot = 6'(got);
                o.load = 1;
            end else o.status = bpq_pkg::STAT_NO_FRAME;
        end
        return o;
    endfunction

    // input transaction seen at the rising edge
    always @(posedge aclk) begin
        s_taken <= s_tvalid && s_tready;
    end

    // request driver
    always @(negedge aclk) begin
        if (s_taken) begin
            n_sent++;
        end
        if (!s_tvalid || s_taken) begin
            if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= 26)) begin
                s_tvalid <= 1;
                s_tdata <= {4'b0, pending_reqs[0].dirty, pending_reqs[0].excl,
                            pending_reqs[0].page};
                s_tuser <= pending_reqs[0].action;
                expected_rsps = {expected_rsps, predict_pool(pending_reqs[0])};
                pending_reqs.delete(0);
            end else s_tvalid <= 0;
        end
        m_tready <= calm || ($urandom_range(99) >= 26);
    end

    // result monitor
    always @(posedge aclk) begin
        rsp_t got, exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[21:0];
            n_recv++;
            if (expected_rsps.size() == 0) begin
                errors++;
                $display("%0t unexpected result %h", $realtime, got);
            end else begin
                exp_r = expected_rsps[0];
                expected_rsps.delete(0);
                if (got.status !== exp_r.status || got.slot !== exp_r.slot ||
                    got.load !== exp_r.load || got.ev !== exp_r.ev ||
                    got.evp !== exp_r.evp || got.wb !== exp_r.wb) begin
                    errors++;
                    $display("%0t mismatch exp st=%0d sl=%0d ld=%b ev=%b evp=%0d wb=%b",
                             $realtime, exp_r.status, exp_r.slot, exp_r.load, exp_r.ev,
                             exp_r.evp, exp_r.wb);
                    $display("%0t          got st=%0d sl=%0d ld=%b ev=%b evp=%0d wb=%b",
                             $realtime, got.status, got.slot, got.load, got.ev,
                             got.evp, got.wb);
                end
            end
        end
    end

    task automatic add_req(bit a, int p, bit e, bit d);
        req_t r;
        r.action = a; r.page = 10'(p); r.excl = e; r.dirty = d;
        pending_reqs = {pending_reqs, r};
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || s_tvalid || expected_rsps.size() != 0)
            @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_limit(int v);
        @(negedge aclk);
        cfg_we <= 1;
        cfg_wdata <= 7'(v);
        @(negedge aclk);
        cfg_we <= 0;
        set_limit(v);
    endtask

    // random phase: mostly a small hot set of pages, fixes mixed with slightly fewer unfixes
    task automatic random_phase(int n, int span);
        int p;
        for (int i = 0; i < n; i++) begin
            p = (($urandom_range(99) < 85) ? $urandom_range(span - 1) : $urandom_range(1023));
            add_req($urandom_range(99) < 45, p, $urandom_range(99) < 20, $urandom_range(1));
        end
    endtask

    initial begin
        pool_reset();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // directed: shared/exclusive conflicts, fixes up to the holder limit, unfix corner cases
        add_req(1, 5, 0, 0);
        add_req(0, 5, 0, 0);
        add_req(0, 5, 1, 0);
        add_req(0, 5, 0, 0);
        add_req(1, 5, 0, 1);
        add_req(1, 5, 0, 0);
        add_req(1, 5, 0, 1);
        add_req(0, 1023, 1, 0);
        add_req(0, 1023, 0, 0);
        add_req(1, 1023, 0, 0);
        add_req(0, 1023, 0, 0);
        for (int i = 0; i < 15; i++) add_req(0, 0, 0, 0);
        drain();

        // limit of one: evictions, writeback and no frame cases
        write_limit(1);
        for (int i = 0; i < 15; i++) add_req(1, 0, 0, 1);
        add_req(0, 7, 0, 0);
        add_req(0, 8, 0, 0);
        add_req(1, 8, 0, 0);
        add_req(0, 9, 1, 0);
        drain();
        write_limit(0);
        add_req(0, 10, 0, 0);
        add_req(1, 9, 0, 1);
        add_req(0, 11, 0, 0);
        drain();

        write_limit(4);
        random_phase(200, 12);
        drain();
        write_limit(64);
        random_phase(200, 120);
        drain();
        write_limit(127);
        random_phase(140, 90);
        drain();
        write_limit(2);
        random_phase(120, 10);
        drain();
        calm = 1;
        write_limit(17);
        random_phase(142, 40);
        drain();

        $display("covered %0d requests and %0d results over limits 0,1,2,4,17,64,127",
                 n_sent, n_recv);
        if (errors == 0) $display("PASS buffer_pool_2q_replacement_core");
        else $display("FAIL buffer_pool_2q_replacement_core");
        $finish;
    end

    initial begin
        #500000;
        $display("FAIL buffer_pool_2q_replacement_core");
        $finish;
    end

endmodule

[sim.f]
src/bpq_pkg.sv
src/bpq_ctrl.sv
src/bpq_dp.sv
src/buffer_pool_2q_replacement_core.sv
tb/buffer_pool_2q_replacement_core_tb.sv
